// ===== src/plist_pkg.sv =====
// package for the positional list unit
// holds the list depth, derived widths, request mode codes and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package plist_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IN_BITS  = MODE_W + VALUE_W + POS_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STAT_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_HEAD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_TAIL = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_POS  = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== src/positional_list_insert_delete_unit.sv =====
// top level of the positional list unit: ordered list with insert/delete by position
// request register, parallel shift of the entry registers, result register
// depends on plist_pkg
//
//  channel  dir  tdata fields (lsb first)               tuser  tlast
//  s_axis   in   mode[2:0] value[34:3] position[42:35]  -      -
//  m_axis   out  status[1:0] count[6:2]                 -      -
//
// one transaction per cycle sustained while the result is accepted; a request waits in the request
// register, and its result is written into the result register together with the
// parallel shift of all entry registers at once
// rst clears the entry count and both valid flags; entry contents are not cleared
// a stalled result holds the result register and the request register behind it
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // mode, value, position, zero fill
  input  wire  [plist_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // status, count, zero fill
  output logic [plist_pkg::OUT_W-1:0]   m_axis_tdata
);
  import plist_pkg::*;

  // request register
  logic                      req_valid;
  logic [MODE_W-1:0]         req_mode;
  logic signed [VALUE_W-1:0] req_value;
  logic [POS_W-1:0]          req_pos;

  // list state
  logic signed [VALUE_W-1:0] entries [DEPTH];
  logic signed [VALUE_W-1:0] entries_next [DEPTH];
  logic signed [VALUE_W-1:0] from_below [DEPTH];
  logic signed [VALUE_W-1:0] from_above [DEPTH];
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_next;

  // result register
  logic [STAT_W-1:0]         res_status;
  logic [COUNT_W-1:0]        res_count;

  logic                      out_free;
  logic                      commit;
  logic [STAT_W-1:0]         status_next;
  logic                      do_ins;
  logic                      do_del;
  logic [POS_W:0]            slot_wide;
  logic [IDX_W-1:0]          slot;
  logic [POS_W:0]            cnt_ext;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign commit        = req_valid && out_free;
  assign s_axis_tready = !req_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_mode  <= s_axis_tdata[MODE_W-1:0];
      req_value <= s_axis_tdata[MODE_W +: VALUE_W];
      req_pos   <= s_axis_tdata[MODE_W+VALUE_W +: POS_W];
    end
  end

  // request decode
  assign cnt_ext = (POS_W+1)'(cnt);

  always_comb begin
    status_next = ST_DONE;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    slot_wide   = '0;
    case (req_mode)
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
        if (cnt >= CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else if (req_mode == MODE_INS_HEAD) begin
          do_ins = 1'b1;
        end else if (req_mode == MODE_INS_TAIL) begin
          do_ins    = 1'b1;
          slot_wide = cnt_ext;
        end else if (req_pos <= POS_W'(1)) begin
          do_ins = 1'b1;
        end else if ({1'b0, req_pos} > cnt_ext + 1'b1) begin
          status_next = ST_RANGE;
        end else begin
          do_ins    = 1'b1;
          slot_wide = {1'b0, req_pos} - 1'b1;
        end
      end
      MODE_DEL_HEAD, MODE_DEL_TAIL, MODE_DEL_POS: begin
        if (cnt == '0) begin
          status_next = ST_EMPTY;
        end else if (req_mode == MODE_DEL_HEAD) begin
          do_del = 1'b1;
        end else if (req_mode == MODE_DEL_TAIL) begin
          do_del    = 1'b1;
          slot_wide = cnt_ext - 1'b1;
        end else if (req_pos == '0 || {1'b0, req_pos} > cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          do_del    = 1'b1;
          slot_wide = {1'b0, req_pos} - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  assign slot = slot_wide[IDX_W-1:0];

  // neighbor taps for the parallel shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign from_below[g] = entries[g];
    end else begin : g_mid
      assign from_below[g] = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign from_above[g] = entries[g];
    end else begin : g_up
      assign from_above[g] = entries[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins && IDX_W'(i) == slot) begin
        entries_next[i] = req_value;
      end else if (do_ins && IDX_W'(i) > slot) begin
        entries_next[i] = from_below[i];
      end else if (do_del && IDX_W'(i) >= slot) begin
        entries_next[i] = from_above[i];
      end else begin
        entries_next[i] = entries[i];
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (do_ins) begin
      cnt_next = cnt + 1'b1;
    end else if (do_del) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (commit) begin
        cnt <= cnt_next;
      end
      if (out_free) begin
        m_axis_tvalid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_status <= status_next;
      res_count  <= COUNT_W'(cnt_next);
    end
  end

  assign m_axis_tdata = OUT_W'({res_count, res_status});

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(cnt))
    else $error("entry count changed without a committed request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_status == ST_FULL |-> res_count == COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_status == ST_EMPTY |-> res_count == '0)
    else $error("empty status with nonzero count");

  a_result_cnt: assert property (@(posedge clk) disable iff (rst)
    commit |=> res_count == COUNT_W'(cnt))
    else $error("reported count differs from held count");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for positional_list_insert_delete_unit: directed and random insert/delete requests
// checks every status/count result against a list predictor kept in the testbench
// depends on plist_pkg and the positional_list_insert_delete_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import plist_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic [MODE_W-1:0]         mode;
  } list_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } list_res_t;

  localparam int RAND_ITEMS  = 1750;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 200;
  localparam int PAUSE_AT    = 700;
  localparam int QUIET_LO    = 1000;
  localparam int QUIET_HI    = 1300;
  localparam int IDLE_PCT    = 9;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_valid = 1'b0;
  logic [IN_W-1:0] s_data = '0;
  logic m_ready = 1'b0;
  wire  s_ready;
  wire  m_valid;
  wire  [OUT_W-1:0] m_data;

  list_req_t pend_q[$];
  list_res_t result_q[$];
  logic signed [VALUE_W-1:0] list_vals[$];
  list_req_t cur_req;
  int gen_cnt = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  int err_cnt = 0;
  int hold_left = 0;
  logic held = 1'b0;

  positional_list_insert_delete_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic is_insert(input logic [MODE_W-1:0] m);
    return m == MODE_INS_HEAD || m == MODE_INS_TAIL || m == MODE_INS_POS;
  endfunction

  function automatic logic is_delete(input logic [MODE_W-1:0] m);
    return m == MODE_DEL_HEAD || m == MODE_DEL_TAIL || m == MODE_DEL_POS;
  endfunction

  // status and count after a request applied to a list holding n entries
  function automatic list_res_t req_outcome(input list_req_t r, input int n);
    list_res_t o;
    int p;
    p = int'(r.position);
    o.status = ST_DONE;
    o.count = COUNT_W'(n);
    if (is_insert(r.mode)) begin
      if (n >= DEPTH) o.status = ST_FULL;
      else if (r.mode == MODE_INS_POS && p > 1 && p > n + 1) o.status = ST_RANGE;
      else o.count = COUNT_W'(n + 1);
    end else if (is_delete(r.mode)) begin
      if (n == 0) o.status = ST_EMPTY;
      else if (r.mode == MODE_DEL_POS && (p < 1 || p > n)) o.status = ST_RANGE;
      else o.count = COUNT_W'(n - 1);
    end
    return o;
  endfunction

  // 0-based slot touched by a request that succeeds
  function automatic int req_slot(input list_req_t r, input int n);
    case (r.mode)
      MODE_INS_TAIL: return n;
      MODE_INS_POS:  return (r.position <= 1) ? 0 : int'(r.position) - 1;
      MODE_DEL_TAIL: return n - 1;
      MODE_DEL_POS:  return int'(r.position) - 1;
      default:       return 0;
    endcase
  endfunction

  task automatic push_req(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v,
                          input logic [POS_W-1:0] p);
    list_req_t r;
    list_res_t o;
    r.mode = m;
    r.value = v;
    r.position = p;
    pend_q.push_back(r);
    o = req_outcome(r, gen_cnt);
    gen_cnt = int'(o.count);
  endtask

  task automatic apply_to_list(input list_req_t r);
    list_res_t o;
    int n;
    int k;
    n = list_vals.size();
    o = req_outcome(r, n);
    k = req_slot(r, n);
    if (o.status == ST_DONE && is_insert(r.mode)) list_vals.insert(k, r.value);
    else if (o.status == ST_DONE && is_delete(r.mode)) list_vals.delete(k);
    result_q.push_back(o);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // driver
  int   sent_next;
  logic tx_idle;
  always @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_data <= '0;
      sent_cnt <= 0;
    end else begin
      sent_next = sent_cnt;
      if (s_valid && s_ready) begin
        apply_to_list(cur_req);
        sent_next = sent_cnt + 1;
      end
      sent_cnt <= sent_next;
      if (!s_valid || s_ready) begin
        tx_idle = (sent_next < QUIET_LO || sent_next >= QUIET_HI) &&
                  ($urandom_range(0, 99) < IDLE_PCT);
        if (sent_next == PAUSE_AT && got_cnt != sent_next) tx_idle = 1'b1;
        if (pend_q.size() != 0 && !tx_idle) begin
          cur_req = pend_q.pop_front();
          s_valid <= 1'b1;
          s_data <= {{(IN_W - IN_BITS){1'b0}}, cur_req};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
      hold_left <= 0;
      held <= 1'b0;
    end else if (hold_left != 0) begin
      m_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && got_cnt >= HOLD_AT) begin
      held <= 1'b1;
      hold_left <= HOLD_LEN;
      m_ready <= 1'b0;
    end else if (got_cnt >= QUIET_LO && got_cnt < QUIET_HI) begin
      m_ready <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor
  list_res_t got_res;
  list_res_t want_res;
  always @(posedge clk) begin
    if (rst) begin
      got_cnt <= 0;
    end else if (m_valid && m_ready) begin
      got_res = m_data[OUT_BITS-1:0];
      if (result_q.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d count=%0d",
                 $time, got_res.status, got_res.count);
        err_cnt++;
      end else begin
        want_res = result_q.pop_front();
        if (got_res.status != want_res.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want_res.status, got_res.status);
          err_cnt++;
        end
        if (got_res.count != want_res.count) begin
          $display("%0t: count mismatch expected %0d actual %0d",
                   $time, want_res.count, got_res.count);
          err_cnt++;
        end
      end
      got_cnt <= got_cnt + 1;
    end
  end

  initial begin
    int i;
    int target;
    int roll;
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0] p;

    // empty list cases
    push_req(MODE_DEL_HEAD, 32'h1234_5678, 8'd0);
    push_req(MODE_DEL_TAIL, 32'h0, 8'd0);
    push_req(MODE_DEL_POS, 32'h0, 8'd1);
    push_req(MODE_INS_POS, 32'h5555_aaaa, 8'd2);
    push_req(MODE_INS_POS, 32'haaaa_5555, 8'd255);
    push_req(3'd6, 32'hffff_ffff, 8'd255);
    push_req(3'd7, 32'h0, 8'd0);
    // position 0 means head, then empty via tail delete of one entry
    push_req(MODE_INS_POS, 32'h8000_0000, 8'd0);
    push_req(MODE_DEL_TAIL, 32'h0, 8'd0);
    push_req(MODE_INS_POS, 32'h7fff_ffff, 8'd1);
    push_req(MODE_INS_HEAD, 32'hffff_ffff, 8'd0);
    push_req(MODE_INS_TAIL, 32'h0, 8'd0);
    push_req(MODE_INS_POS, 32'h0000_0001, 8'd6);
    push_req(MODE_DEL_POS, 32'h0, 8'd0);
    push_req(MODE_DEL_POS, 32'h0, 8'd4);
    // fill to full at count+1
    while (gen_cnt < DEPTH) push_req(MODE_INS_POS, $urandom, 8'(gen_cnt + 1));
    push_req(MODE_INS_HEAD, 32'h1, 8'd0);
    push_req(MODE_INS_TAIL, 32'h2, 8'd0);
    push_req(MODE_INS_POS, 32'h3, 8'd1);
    push_req(MODE_DEL_POS, 32'h0, 8'd17);
    push_req(MODE_DEL_POS, 32'h0, 8'd16);
    push_req(MODE_DEL_HEAD, 32'h0, 8'd0);

    target = 0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       target = 0;
          1:       target = DEPTH;
          default: target = $urandom_range(0, DEPTH);
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_req(3'($urandom_range(6, 7)), pick_value(), 8'($urandom_range(0, 255)));
      end else if (roll < 12) begin
        push_req(3'($urandom_range(0, 5)), pick_value(), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 99) < ((gen_cnt < target) ? 75 : 25)) begin
          m = 3'($urandom_range(0, 2));
          p = 8'($urandom_range(0, gen_cnt + 1));
        end else begin
          m = 3'($urandom_range(3, 5));
          p = 8'($urandom_range(1, (gen_cnt == 0) ? 1 : gen_cnt));
        end
        push_req(m, pick_value(), p);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pend_q.size() != 0 || s_valid || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS positional_list_insert_delete_unit");
    end else begin
      $display("FAIL positional_list_insert_delete_unit");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL positional_list_insert_delete_unit");
    $finish;
  end

endmodule

// ===== sim.f =====
src/plist_pkg.sv
src/positional_list_insert_delete_unit.sv
verif/tb_top.sv
